FILE: hdl/auoi_pkg.sv
// Shared types and constants for the unwind opcode interpreter.
package auoi_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;
   localparam logic [1:0] OP_UNDEF = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FINISHED = 3'd1;
   localparam logic [2:0] ST_REFUSE   = 3'd2;
   localparam logic [2:0] ST_FORMAT   = 3'd3;
   localparam logic [2:0] ST_TRUNC    = 3'd4;
   localparam logic [2:0] ST_IGNORED  = 3'd5;

   localparam logic [7:0] OPC_FINISH = 8'hb0;
   localparam logic [31:0] ULEB_BIAS = 32'h204;

   localparam logic [3:0] REG_SP = 4'd13;
   localparam logic [3:0] REG_LR = 4'd14;

   // command from controller to datapath
   typedef struct packed {
      logic        load;      // take new input word into datapath
      logic        exec;      // run decode of the held word, commit state
      logic        pop;       // emit pop of lowest pending mask bit
      logic        emit_stat; // present status word
   } cmd_type;

   typedef struct packed {
      logic        mask_empty; // no pops left
   } stat_type;

endpackage

FILE: hdl/arm_unwind_opcode_interpreter.sv
// Top level of the unwind opcode interpreter.
// Each accepted word is decoded and executed, then one pop word is sent per pending mask bit, then the status word.
// A new word is accepted only after the status word of the previous one has been taken.
// The pop count (0 to 12) is set by the serial pop mask walk in the datapath.
// Synchronous reset: stack pointer and registers zero, frame marked done.
module arm_unwind_opcode_interpreter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // operation[1:0], reg_index[5:2], value[37:6],
                                   // opcode_byte[45:38], zero pad
   input  logic        req_tlast,  // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // pop_register[3:0], pop_address[35:4],
                                   // stack_pointer[67:36], status[70:68], pc_popped[71]
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast   // last
);
   auoi_pkg::cmd_type  cmd;
   auoi_pkg::stat_type stat;
   logic        kind, pc, lst;
   logic [3:0]  rg;
   logic [31:0] addr, sp;
   logic [2:0]  st;

   auoi_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   auoi_dp u_dp (
      .clock(clock), .reset(reset),
      .in_op(req_tdata[1:0]), .in_reg(req_tdata[5:2]), .in_value(req_tdata[37:6]),
      .in_byte(req_tdata[45:38]), .in_last(req_tlast),
      .cmd(cmd), .stat(stat),
      .rsp_kind(kind), .rsp_reg(rg), .rsp_addr(addr), .rsp_sp(sp),
      .rsp_status(st), .rsp_pc(pc), .rsp_last(lst)
   );

   assign rsp_tdata = {pc, st, sp, addr, rg};
   assign rsp_tuser = kind;
   assign rsp_tlast = lst;
endmodule

FILE: hdl/auoi_ctrl.sv
// Controller: sequences load, execute, pops and status output.
module auoi_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output auoi_pkg::cmd_type  cmd,
   input  auoi_pkg::stat_type stat
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_POP  = 2'd2;
   localparam logic [1:0] S_STAT = 2'd3;

   logic [1:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ((state_ff == S_POP) && !stat.mask_empty) || (state_ff == S_STAT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_POP;
         end
         S_POP: begin
            if (stat.mask_empty) begin
               state_in = S_STAT;
            end else if (rsp_tready) begin
               cmd.pop = 1'b1;
            end
         end
         S_STAT: begin
            cmd.emit_stat = 1'b1;
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

FILE: hdl/auoi_dp.sv
// Datapath: unwind state, opcode decode and pop address generation.
module auoi_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         in_op,
   input  logic [3:0]         in_reg,
   input  logic [31:0]        in_value,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  auoi_pkg::cmd_type  cmd,
   output auoi_pkg::stat_type stat,
   output logic               rsp_kind,
   output logic [3:0]         rsp_reg,
   output logic [31:0]        rsp_addr,
   output logic [31:0]        rsp_sp,
   output logic [2:0]         rsp_status,
   output logic               rsp_pc,
   output logic               rsp_last
);
   logic [1:0]  op_ff;
   logic [3:0]  ri_ff;
   logic [31:0] val_ff;
   logic [7:0]  b_ff;
   logic        lastb_ff;

   logic [31:0] sp_ff, sp_in;
   logic [31:0] rf_ff [16];
   logic [7:0]  pend_ff, pend_in;
   logic        pv_ff, pv_in;
   logic [31:0] ul_ff, ul_in;
   logic [5:0]  sh_ff, sh_in;
   logic        r13_ff, r13_in;
   logic        pc_ff, pc_in;
   logic        done_ff, done_in;
   logic [15:0] mask_ff, mask_in;
   logic [2:0]  st_ff, st_in;

   logic [3:0]  low_idx;
   logic [31:0] spw;
   logic [11:0] m12;
   logic [2:0]  s;
   logic [31:0] sh7;

   always_comb begin
      low_idx = '0;
      for (int i = 15; i >= 0; i--) begin
         if (mask_ff[i]) low_idx = 4'(i);
      end
   end

   assign stat.mask_empty = (mask_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         ri_ff <= in_reg;
         val_ff <= in_value;
         b_ff <= in_byte;
         lastb_ff <= in_last;
      end
      if (reset) begin
         for (int i = 0; i < 16; i++) rf_ff[i] <= '0;
      end else if (cmd.exec && op_ff == auoi_pkg::OP_WRITE) begin
         rf_ff[ri_ff] <= val_ff;
      end
   end

   always_comb begin
      sp_in = sp_ff; pend_in = pend_ff; pv_in = pv_ff; ul_in = ul_ff; sh_in = sh_ff;
      r13_in = r13_ff; pc_in = pc_ff; done_in = done_ff; mask_in = mask_ff; st_in = st_ff;
      spw = r13_ff ? rf_ff[auoi_pkg::REG_SP] : sp_ff;
      m12 = {pend_ff[3:0], b_ff};
      s = auoi_pkg::ST_OK;
      sh7 = 32'({b_ff[6:0]}) << sh_ff[4:0];
      if (cmd.pop) begin
         mask_in[low_idx] = 1'b0;
         sp_in = sp_ff + 32'd4;
      end else if (cmd.exec) begin
         case (op_ff)
            auoi_pkg::OP_START: begin
               sp_in = val_ff; pend_in = '0; pv_in = 1'b0; ul_in = '0; sh_in = '0;
               r13_in = 1'b0; pc_in = 1'b0; done_in = 1'b0; st_in = auoi_pkg::ST_OK;
            end
            auoi_pkg::OP_WRITE: begin
               if (ri_ff == auoi_pkg::REG_SP && r13_ff) begin
                  sp_in = val_ff; r13_in = 1'b0;
               end
               st_in = auoi_pkg::ST_OK;
            end
            auoi_pkg::OP_UNDEF: st_in = auoi_pkg::ST_FORMAT;
            default: begin
               if (done_ff) begin
                  st_in = auoi_pkg::ST_IGNORED;
               end else begin
                  r13_in = 1'b0;
                  sp_in = spw;
                  if (pv_ff) begin
                     pv_in = 1'b0;
                     if (pend_ff[7:4] == 4'h8) begin
                        if (m12 == '0) s = auoi_pkg::ST_REFUSE;
                        else begin
                           if (m12[11]) pc_in = 1'b1;
                           if (m12[9]) r13_in = 1'b1;
                           mask_in = {m12, 4'b0};
                        end
                     end else begin
                        case (pend_ff)
                           8'hb1: begin
                              if (b_ff == 8'd0 || b_ff[7:4] != 4'd0) s = auoi_pkg::ST_FORMAT;
                              else mask_in = {12'd0, b_ff[3:0]};
                           end
                           8'hb2: begin
                              if (sh_ff < 6'd32) begin
                                 ul_in = ul_ff | sh7;
                                 sh_in = sh_ff + 6'd7;
                              end
                              if (b_ff[7]) pv_in = 1'b1;
                              else begin
                                 sp_in = spw + auoi_pkg::ULEB_BIAS + {ul_in[29:0], 2'b00};
                                 ul_in = '0; sh_in = '0;
                              end
                           end
                           8'hb3: sp_in = spw + {25'd0, 4'(b_ff[3:0] + 4'd0), 3'b0}
                                    + 32'd12;
                           8'hc6, 8'hc8, 8'hc9:
                              sp_in = spw + {25'd0, b_ff[3:0], 3'b0} + 32'd8;
                           8'hc7: begin
                              if (b_ff == 8'd0 || b_ff[7:4] != 4'd0) s = auoi_pkg::ST_FORMAT;
                              else sp_in = spw + {27'd0, {2'd0, b_ff[0]} + {2'd0, b_ff[1]}
                                          + {2'd0, b_ff[2]} + {2'd0, b_ff[3]}, 2'b00};
                           end
                           default: s = auoi_pkg::ST_FORMAT;
                        endcase
                     end
                  end else if (b_ff[7:4] == 4'h8 || b_ff == 8'hb1 || b_ff == 8'hb2 ||
                               b_ff == 8'hb3 || b_ff == 8'hc6 || b_ff == 8'hc7 ||
                               b_ff == 8'hc8 || b_ff == 8'hc9) begin
                     pend_in = b_ff; pv_in = 1'b1; ul_in = '0; sh_in = '0;
                  end else begin
                     case (b_ff[7:6])
                        2'd0: sp_in = spw + {24'd0, b_ff[5:0], 2'b00} + 32'd4;
                        2'd1: sp_in = spw - {24'd0, b_ff[5:0], 2'b00} - 32'd4;
                        2'd2: begin
                           if (b_ff[7:4] == 4'h9) begin
                              if (b_ff[3:0] == 4'd13 || b_ff[3:0] == 4'd15)
                                 s = auoi_pkg::ST_FORMAT;
                              else sp_in = rf_ff[b_ff[3:0]];
                           end else if (b_ff[7:4] == 4'ha) begin
                              mask_in = '0;
                              for (int i = 0; i < 8; i++) begin
                                 if (i <= int'(b_ff[2:0])) mask_in[4 + i] = 1'b1;
                              end
                              mask_in[auoi_pkg::REG_LR] = b_ff[3];
                           end else if (b_ff == auoi_pkg::OPC_FINISH) begin
                              s = auoi_pkg::ST_FINISHED;
                           end else if (b_ff[7:3] == 5'b10111) begin
                              sp_in = spw + {26'd0, b_ff[2:0], 3'b0} + 32'd12;
                           end else s = auoi_pkg::ST_FORMAT;
                        end
                        default: begin
                           if (b_ff[7:3] == 5'b11000 || b_ff[7:3] == 5'b11010)
                              sp_in = spw + {26'd0, b_ff[2:0], 3'b0} + 32'd8;
                           else s = auoi_pkg::ST_FORMAT;
                        end
                     endcase
                  end
                  if (s == auoi_pkg::ST_OK && lastb_ff)
                     s = pv_in ? auoi_pkg::ST_TRUNC : auoi_pkg::ST_FINISHED;
                  if (s != auoi_pkg::ST_OK) begin
                     done_in = 1'b1; pv_in = 1'b0; pend_in = '0; ul_in = '0; sh_in = '0;
                  end
                  st_in = s;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0; pend_ff <= '0; pv_ff <= 1'b0; ul_ff <= '0; sh_ff <= '0;
         r13_ff <= 1'b0; pc_ff <= 1'b0; done_ff <= 1'b1; mask_ff <= '0; st_ff <= '0;
      end else begin
         sp_ff <= sp_in; pend_ff <= pend_in; pv_ff <= pv_in; ul_ff <= ul_in; sh_ff <= sh_in;
         r13_ff <= r13_in; pc_ff <= pc_in; done_ff <= done_in; mask_ff <= mask_in;
         st_ff <= st_in;
      end
   end

   assign rsp_kind   = cmd.emit_stat;
   assign rsp_reg    = cmd.emit_stat ? 4'd0 : low_idx;
   assign rsp_addr   = cmd.emit_stat ? 32'd0 : sp_ff;
   assign rsp_sp     = cmd.emit_stat ? sp_ff : sp_ff + 32'd4;
   assign rsp_status = cmd.emit_stat ? st_ff : auoi_pkg::ST_OK;
   assign rsp_pc     = pc_ff;
   assign rsp_last   = cmd.emit_stat;
endmodule

FILE: sim/unwind_checker.sv
// Checker for the unwind opcode interpreter: predicts result words and compares them.
`timescale 1ns / 1ps
module unwind_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic        kind;
      logic [3:0]  pop_reg;
      logic [31:0] pop_addr;
      logic [31:0] sp;
      logic [2:0]  status;
      logic        pc_popped;
      logic        last;
   } rsp_word_type;

   rsp_word_type expected_words[$];
   logic [31:0] sp;
   logic [31:0] regs[16];
   logic [7:0]  held_op;
   logic        held_valid;
   logic [31:0] uleb_acc;
   logic [5:0]  uleb_sh;
   logic        sp_lazy;
   logic        pc_flag;
   logic        done;

   assign pending_count = expected_words.size();

   function automatic rsp_word_type word_of(logic kind, logic [3:0] r, logic [31:0] a,
                                            logic [2:0] st);
      rsp_word_type w;
      w.kind = kind;
      w.pop_reg = r;
      w.pop_addr = a;
      w.sp = sp;
      w.status = st;
      w.pc_popped = pc_flag;
      w.last = 1'b0;
      return w;
   endfunction

   task automatic pop_reg(input logic [3:0] r);
      logic [31:0] a;
      a = sp;
      sp = sp + 32'd4;
      expected_words.push_back(word_of(1'b0, r, a, auoi_pkg::ST_OK));
   endtask

   function automatic logic takes_second(logic [7:0] b);
      return b[7:4] == 4'h8 || b == 8'hb1 || b == 8'hb2 || b == 8'hb3 ||
             b == 8'hc6 || b == 8'hc7 || b == 8'hc8 || b == 8'hc9;
   endfunction

   task automatic run_first(input logic [7:0] b, output logic [2:0] st);
      st = auoi_pkg::ST_OK;
      if (takes_second(b)) begin
         held_op = b;
         held_valid = 1'b1;
         uleb_acc = '0;
         uleb_sh = '0;
      end else if (b[7:6] == 2'd0) begin
         sp = sp + {b[5:0], 2'b00} + 32'd4;
      end else if (b[7:6] == 2'd1) begin
         sp = sp - ({b[5:0], 2'b00} + 32'd4);
      end else if (b[7:4] == 4'h9) begin
         if (b[3:0] == auoi_pkg::REG_SP || b[3:0] == 4'd15) st = auoi_pkg::ST_FORMAT;
         else sp = regs[b[3:0]];
      end else if (b[7:4] == 4'ha) begin
         for (int i = 0; i <= b[2:0]; i++) pop_reg(4'(i + 4));
         if (b[3]) pop_reg(auoi_pkg::REG_LR);
      end else if (b == auoi_pkg::OPC_FINISH) begin
         st = auoi_pkg::ST_FINISHED;
      end else if (b[7:3] == 5'b10111) begin
         sp = sp + (b[2:0] + 32'd1) * 8 + 4;
      end else if (b[7:3] == 5'b11000 || b[7:3] == 5'b11010) begin
         sp = sp + (b[2:0] + 32'd1) * 8;
      end else begin
         st = auoi_pkg::ST_FORMAT;
      end
   endtask

   task automatic run_second(input logic [7:0] b, output logic [2:0] st);
      logic [11:0] mask;
      st = auoi_pkg::ST_OK;
      held_valid = 1'b0;
      if (held_op[7:4] == 4'h8) begin
         mask = {held_op[3:0], b};
         if (mask == 0) begin
            st = auoi_pkg::ST_REFUSE;
         end else begin
            if (mask[11]) pc_flag = 1'b1;
            for (int i = 0; i < 12; i++) if (mask[i]) pop_reg(4'(i + 4));
            if (mask[9]) sp_lazy = 1'b1;
         end
      end else begin
         case (held_op)
            8'hb1: begin
               if (b == 0 || b[7:4] != 0) st = auoi_pkg::ST_FORMAT;
               else for (int i = 0; i < 4; i++) if (b[i]) pop_reg(4'(i));
            end
            8'hb2: begin
               if (uleb_sh < 32) begin
                  uleb_acc = uleb_acc | (32'(b[6:0]) << uleb_sh);
                  uleb_sh = uleb_sh + 6'd7;
               end
               if (b[7]) begin
                  held_valid = 1'b1;
               end else begin
                  sp = sp + auoi_pkg::ULEB_BIAS + (uleb_acc << 2);
                  uleb_acc = '0;
                  uleb_sh = '0;
               end
            end
            8'hb3: sp = sp + (b[3:0] + 32'd1) * 8 + 4;
            8'hc6, 8'hc8, 8'hc9: sp = sp + (b[3:0] + 32'd1) * 8;
            8'hc7: begin
               if (b == 0 || b[7:4] != 0) st = auoi_pkg::ST_FORMAT;
               else sp = sp + (b[0] + b[1] + b[2] + b[3]) * 32'd4;
            end
            default: st = auoi_pkg::ST_FORMAT;
         endcase
      end
   endtask

   task automatic predict(input logic [47:0] d, input logic lastb);
      logic [1:0]   op;
      logic [3:0]   ri;
      logic [31:0]  v;
      logic [7:0]   b;
      logic [2:0]   st;
      rsp_word_type w;
      op = d[1:0];
      ri = d[5:2];
      v = d[37:6];
      b = d[45:38];
      if (op == auoi_pkg::OP_START) begin
         sp = v;
         held_op = '0;
         held_valid = 0;
         uleb_acc = '0;
         uleb_sh = '0;
         sp_lazy = 0;
         pc_flag = 0;
         done = 0;
         st = auoi_pkg::ST_OK;
      end else if (op == auoi_pkg::OP_WRITE) begin
         regs[ri] = v;
         if (ri == auoi_pkg::REG_SP && sp_lazy) begin
            sp = v;
            sp_lazy = 0;
         end
         st = auoi_pkg::ST_OK;
      end else if (op == auoi_pkg::OP_UNDEF) begin
         st = auoi_pkg::ST_FORMAT;
      end else if (done) begin
         st = auoi_pkg::ST_IGNORED;
      end else begin
         if (sp_lazy) begin
            sp = regs[auoi_pkg::REG_SP];
            sp_lazy = 0;
         end
         if (held_valid) run_second(b, st);
         else run_first(b, st);
         if (st == auoi_pkg::ST_OK && lastb)
            st = held_valid ? auoi_pkg::ST_TRUNC : auoi_pkg::ST_FINISHED;
         if (st != auoi_pkg::ST_OK) begin
            done = 1;
            held_valid = 0;
            held_op = '0;
            uleb_acc = '0;
            uleb_sh = '0;
         end
      end
      w = word_of(1'b1, 4'd0, 32'd0, st);
      w.last = 1'b1;
      expected_words.push_back(w);
   endtask

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (reset) begin
         expected_words.delete();
         for (int i = 0; i < 16; i++) regs[i] = '0;
         held_op = '0;
         held_valid = 0;
         uleb_acc = '0;
         uleb_sh = '0;
         sp_lazy = 0;
         pc_flag = 0;
         done = 1;
         sp = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[3:0], rsp_tdata[35:4], rsp_tdata[67:36],
                   rsp_tdata[70:68], rsp_tdata[71], rsp_tlast};
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("mismatch: expected kind=%0d reg=%0d addr=%h sp=%h st=%0d",
                        want.kind, want.pop_reg, want.pop_addr, want.sp, want.status,
                        " pc=%0d last=%0d", want.pc_popped, want.last);
                     $display("          got      kind=%0d reg=%0d addr=%h sp=%h st=%0d",
                        got.kind, got.pop_reg, got.pop_addr, got.sp, got.status,
                        " pc=%0d last=%0d", got.pc_popped, got.last);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) predict(req_tdata, req_tlast);
      end
   end

   initial fail_count = 0;

endmodule

FILE: sim/tb_arm_unwind_opcode_interpreter.sv
// Testbench top for the unwind opcode interpreter: stimulus and verdict.
`timescale 1ns / 1ps
module tb_arm_unwind_opcode_interpreter;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          fail_count;
   int          pending_count;

   arm_unwind_opcode_interpreter dut (.*);

   unwind_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .fail_count, .pending_count
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side stalls, drawn per word
   initial begin
      int gap;
      rsp_tready = 0;
      forever begin
         gap = $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   task automatic send_word(input logic [1:0] op, input logic [3:0] ri,
                            input logic [31:0] v, input logic [7:0] b, input logic lastb);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {2'b00, b, v, ri, op};
      req_tlast <= lastb;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic lastb);
      send_word(auoi_pkg::OP_BYTE, 4'($urandom), $urandom, b, lastb);
   endtask

   task automatic start_frame(input logic [31:0] v);
      send_word(auoi_pkg::OP_START, 4'($urandom), v, 8'($urandom), 1'($urandom));
   endtask

   function automatic logic [7:0] rand_opcode();
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(0, 8'h7f));
         1: return 8'h80 | 8'($urandom_range(0, 15));
         2: return 8'h90 | 8'($urandom_range(0, 15));
         3: return 8'ha0 | 8'($urandom_range(0, 15));
         4: return 8'hb0 + 8'($urandom_range(1, 3));
         5: return 8'hb8 | 8'($urandom_range(0, 7));
         6: return 8'hc0 + 8'($urandom_range(0, 9));
         7: return 8'hd0 | 8'($urandom_range(0, 7));
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      int n;
      int len;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_byte(8'h00, 0);
      send_word(auoi_pkg::OP_UNDEF, 4'hf, 32'hffffffff, 8'hff, 1);
      for (int i = 0; i < 16; i++) send_word(auoi_pkg::OP_WRITE, 4'(i), $urandom, 8'h00, 0);
      start_frame(32'hfffffff0);
      send_byte(8'h3f, 0);
      send_byte(8'h7f, 0);
      send_byte(8'h8f, 0);
      send_byte(8'hff, 0);
      send_word(auoi_pkg::OP_WRITE, auoi_pkg::REG_SP, 32'h1000, 8'h00, 0);
      send_byte(8'hb2, 0);
      send_byte(8'hff, 0);
      send_byte(8'hff, 0);
      send_byte(8'hff, 0);
      send_byte(8'hff, 0);
      send_byte(8'hff, 0);
      send_byte(8'h7f, 0);
      send_byte(8'haf, 0);
      send_byte(8'h9d, 0);
      send_byte(8'h00, 0);
      start_frame(32'h0);
      send_byte(8'h80, 0);
      send_byte(8'h00, 0);
      start_frame(32'h0);
      send_byte(8'hb1, 1);
      start_frame(32'h8000);
      send_byte(8'hb0, 0);
      n = 0;
      while (n < 140) begin
         start_frame($urandom);
         n++;
         len = $urandom_range(1, 8);
         for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
               0: send_word(auoi_pkg::OP_WRITE, 4'($urandom), $urandom, 8'($urandom),
                            1'($urandom));
               1: send_word(auoi_pkg::OP_UNDEF, 4'($urandom), $urandom, 8'($urandom),
                            1'($urandom));
               default: send_byte(rand_opcode(), k == len - 1 && $urandom_range(0, 1));
            endcase
            if ($urandom_range(0, 2) == 0) begin
               send_byte(8'($urandom), 0);
               n++;
            end
            n++;
         end
      end
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
